>>> sv/wsu_pkg.sv
// Shared types and constants for the WebSocket frame unmasker.
// Used by every module of the block; depends on nothing else.
package wsu_pkg;

    // Reset values of the configuration registers.
    localparam logic [7:0]  HEADER_RESET  = 8'h81;
    localparam logic [15:0] MAX_LEN_RESET = 16'd4088;

    // Configuration register indexes.
    localparam logic CFG_HEADER  = 1'b0;
    localparam logic CFG_MAX_LEN = 1'b1;

    // Length code field and its special codes.
    localparam logic [6:0] LEN_CODE_MASK = 7'h7F;
    localparam logic [6:0] LEN_EXT16     = 7'd126;
    localparam logic [6:0] LEN_UNSUP     = 7'd127;

    // Mask key size.
    localparam int MASK_BYTES = 4;
    localparam int MASK_IDX_W = $clog2(MASK_BYTES);

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       buffer_start;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [15:0] payload_position;
        logic        last_of_payload;
    } out_beat_t;

    // One classified payload byte waiting to be unmasked.
    typedef struct packed {
        logic [7:0]  data;
        logic [7:0]  mask;
        logic [15:0] position;
        logic        last;
    } work_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

endpackage

>>> sv/websocket_frame_unmasker_unit.sv
// WebSocket client frame deframer and unmasker, top level.
// Instantiates wsu_front, wsu_queue and wsu_back; depends on wsu_pkg.
//
// Received frame bytes enter on the frame channel, one byte per beat, with
// buffer_start marking the first byte of each received buffer. The parser
// checks the header byte, reads the length (7-bit or 16-bit extended form)
// and the four mask bytes, and passes payload bytes on. Each payload beat on
// the payload channel carries the unmasked byte, its position in the payload
// and a last flag. Header, length and mask bytes produce no output beat.
// Two configuration registers, written through cfg_write/cfg_index/cfg_data,
// set the accepted header byte and the longest accepted payload length.
//
// Throughput is one byte per cycle while neither side stalls. A payload byte
// accepted on the frame channel is registered into the queue and then into the
// output register, from which it is presented on the payload channel.
// While the receiver stalls, the output holds and the queue fills; once it
// is full, frame_stall is raised. Reset empties the queue and output, puts
// the parser in idle and loads the register defaults.
module websocket_frame_unmasker_unit
    import wsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    output logic        frame_stall,
    input  in_beat_t    frame_beat,
    output logic        payload_valid,
    input  logic        payload_stall,
    output out_beat_t   payload_beat,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    work_t     push_entry;
    work_t     head;

    wsu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_beat  (frame_beat),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_status    (q_status),
        .push        (push),
        .push_entry  (push_entry)
    );

    wsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    wsu_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .head          (head),
        .pop           (pop),
        .payload_valid (payload_valid),
        .payload_stall (payload_stall),
        .payload_beat  (payload_beat)
    );

endmodule

>>> sv/wsu_front.sv
// Front end: configuration registers and the frame parser.
// Classifies each received byte and queues payload bytes with their mask byte.
// Depends on wsu_pkg.
module wsu_front
    import wsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    output logic        frame_stall,
    input  in_beat_t    frame_beat,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  q_status_t   q_status,
    output logic        push,
    output work_t       push_entry
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN,
        PH_EXT_HI,
        PH_EXT_LO,
        PH_MASK,
        PH_PAYLOAD,
        PH_DROP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] length_reg, length_next;
    logic [31:0] mask_reg, mask_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  header_reg;
    logic [15:0] max_len_reg;

    logic        accept;
    logic [7:0]  b;
    logic [6:0]  code;
    logic [15:0] ext_len;
    logic        last;
    logic [MASK_IDX_W-1:0] midx;

    assign frame_stall = q_status.full;
    assign accept      = frame_valid && !q_status.full;
    assign b           = frame_beat.stream_byte;
    assign code        = b[6:0] & LEN_CODE_MASK;
    assign ext_len     = {length_reg[15:8], b};
    assign midx        = count_reg[MASK_IDX_W-1:0];
    assign last        = ({1'b0, count_reg} + 17'd1) >= {1'b0, length_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        mask_next   = mask_reg;
        count_next  = count_reg;
        push        = 1'b0;
        push_entry.data     = b;
        push_entry.mask     = mask_reg[8*midx +: 8];
        push_entry.position = count_reg;
        push_entry.last     = last;
        if (accept)
        begin
            if (frame_beat.buffer_start)
            begin
                length_next = '0;
                mask_next   = '0;
                count_next  = '0;
                phase_next  = (b == header_reg) ? PH_LEN : PH_DROP;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LEN:
                    begin
                        if (code == LEN_UNSUP)
                        begin
                            phase_next = PH_DROP;
                        end
                        else if (code == LEN_EXT16)
                        begin
                            phase_next = PH_EXT_HI;
                        end
                        else
                        begin
                            length_next = {9'd0, code};
                            if ({9'd0, code} > max_len_reg)
                            begin
                                phase_next = PH_DROP;
                            end
                            else
                            begin
                                phase_next = PH_MASK;
                                count_next = '0;
                            end
                        end
                    end
                    PH_EXT_HI:
                    begin
                        length_next = {b, 8'h00};
                        phase_next  = PH_EXT_LO;
                    end
                    PH_EXT_LO:
                    begin
                        length_next = ext_len;
                        if (ext_len > max_len_reg)
                        begin
                            phase_next = PH_DROP;
                        end
                        else
                        begin
                            phase_next = PH_MASK;
                            count_next = '0;
                        end
                    end
                    PH_MASK:
                    begin
                        mask_next[8*midx +: 8] = b;
                        count_next = count_reg + 16'd1;
                        if (midx == MASK_IDX_W'(MASK_BYTES - 1))
                        begin
                            count_next = '0;
                            phase_next = (length_reg == 16'd0) ? PH_IDLE : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        push       = 1'b1;
                        count_next = count_reg + 16'd1;
                        if (last)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        // Idle or dropping: the byte is ignored.
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            length_reg  <= '0;
            mask_reg    <= '0;
            count_reg   <= '0;
            header_reg  <= HEADER_RESET;
            max_len_reg <= MAX_LEN_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            mask_reg   <= mask_next;
            count_reg  <= count_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_HEADER:  header_reg  <= cfg_data[7:0];
                    CFG_MAX_LEN: max_len_reg <= cfg_data;
                endcase
            end
        end
    end

endmodule

>>> sv/wsu_queue.sv
// Short queue between the parser and the unmasking stage.
// Depends on wsu_pkg for the entry and status types.
module wsu_queue
    import wsu_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  work_t     push_entry,
    input  logic      pop,
    output work_t     head,
    output q_status_t q_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    work_t            slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head               = slots[rd_ptr_reg];
    assign q_status.not_empty = (count_reg != '0);
    assign q_status.full      = (count_reg == CNT_W'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> sv/wsu_back.sv
// Back end: unmasks queued payload bytes into the output register.
// Depends on wsu_pkg.
module wsu_back
    import wsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_status_t q_status,
    input  work_t     head,
    output logic      pop,
    output logic      payload_valid,
    input  logic      payload_stall,
    output out_beat_t payload_beat
);

    logic      valid_reg;
    out_beat_t beat_reg;

    assign pop           = q_status.not_empty && (!valid_reg || !payload_stall);
    assign payload_valid = valid_reg;
    assign payload_beat  = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (!payload_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            beat_reg.payload_byte     <= head.data ^ head.mask;
            beat_reg.payload_position <= head.position;
            beat_reg.last_of_payload  <= head.last;
        end
    end

endmodule

>>> bench/websocket_frame_unmasker_unit_test.sv
`timescale 1ns / 100ps
// Testbench for websocket_frame_unmasker_unit: directed frames, then random frames
// under several register settings, checked beat by beat against a built-in parser model.
// Depends on wsu_pkg and the RTL of the unmasker.
module websocket_frame_unmasker_unit_test;
    import wsu_pkg::*;

    typedef enum logic [2:0] {
        PARSE_IDLE,
        PARSE_LEN,
        PARSE_EXT_HI,
        PARSE_EXT_LO,
        PARSE_MASK,
        PARSE_PAYLOAD,
        PARSE_DROP
    } parse_phase_e;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_SILENT,
        ROW_PINNED
    } row_kind_e;

    typedef struct packed {
        in_beat_t  beat;
        row_kind_e kind;
        out_beat_t pinned;
    } directed_row_t;

    localparam int N_DIRECTED = 33;
    localparam int LONGEST_SEND = 600;

    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{'{8'h81, 1'b1}, ROW_SILENT, '0},
        '{'{8'h82, 1'b0}, ROW_SILENT, '0},
        '{'{8'h00, 1'b0}, ROW_SILENT, '0},
        '{'{8'h00, 1'b0}, ROW_SILENT, '0},
        '{'{8'h00, 1'b0}, ROW_SILENT, '0},
        '{'{8'h00, 1'b0}, ROW_SILENT, '0},
        '{'{8'hFF, 1'b0}, ROW_PINNED, '{8'hFF, 16'd0, 1'b0}},
        '{'{8'h00, 1'b0}, ROW_PINNED, '{8'h00, 16'd1, 1'b1}},
        '{'{8'h55, 1'b0}, ROW_SILENT, '0},
        '{'{8'h00, 1'b1}, ROW_SILENT, '0},
        '{'{8'h81, 1'b0}, ROW_SILENT, '0},
        '{'{8'h81, 1'b1}, ROW_SILENT, '0},
        '{'{8'h7F, 1'b0}, ROW_SILENT, '0},
        '{'{8'h81, 1'b1}, ROW_SILENT, '0},
        '{'{8'hFE, 1'b0}, ROW_SILENT, '0},
        '{'{8'h00, 1'b0}, ROW_SILENT, '0},
        '{'{8'h03, 1'b0}, ROW_SILENT, '0},
        '{'{8'h12, 1'b0}, ROW_SILENT, '0},
        '{'{8'h34, 1'b0}, ROW_SILENT, '0},
        '{'{8'h56, 1'b0}, ROW_SILENT, '0},
        '{'{8'h78, 1'b0}, ROW_SILENT, '0},
        '{'{8'hAA, 1'b0}, ROW_PREDICT, '0},
        '{'{8'h81, 1'b1}, ROW_SILENT, '0},
        '{'{8'h80, 1'b0}, ROW_SILENT, '0},
        '{'{8'hFF, 1'b0}, ROW_SILENT, '0},
        '{'{8'hFF, 1'b0}, ROW_SILENT, '0},
        '{'{8'hFF, 1'b0}, ROW_SILENT, '0},
        '{'{8'hFF, 1'b0}, ROW_SILENT, '0},
        '{'{8'h81, 1'b1}, ROW_SILENT, '0},
        '{'{8'hFE, 1'b0}, ROW_SILENT, '0},
        '{'{8'hFF, 1'b0}, ROW_SILENT, '0},
        '{'{8'hFF, 1'b0}, ROW_SILENT, '0},
        '{'{8'hC3, 1'b0}, ROW_SILENT, '0}
    };

    logic        clk;
    logic        rst_n = 1'b0;
    logic        frame_valid = 1'b0;
    logic        frame_stall;
    in_beat_t    frame_beat = '0;
    logic        payload_valid;
    logic        payload_stall = 1'b0;
    out_beat_t   payload_beat;
    logic        cfg_write = 1'b0;
    logic        cfg_index = CFG_HEADER;
    logic [15:0] cfg_data = '0;

    // Parser model state and its copy of the registers.
    parse_phase_e phase = PARSE_IDLE;
    logic [15:0]  frame_len = '0;
    logic [31:0]  mask_word = '0;
    logic [15:0]  pos_count = '0;
    logic [7:0]   cfg_header = HEADER_RESET;
    logic [15:0]  cfg_max_len = MAX_LEN_RESET;

    out_beat_t expected_payload [$];
    int        mismatch_count = 0;
    int        work_beats = 0;
    int        send_calm = 0;
    int        recv_calm = 0;

    websocket_frame_unmasker_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_valid   (frame_valid),
        .frame_stall   (frame_stall),
        .frame_beat    (frame_beat),
        .payload_valid (payload_valid),
        .payload_stall (payload_stall),
        .payload_beat  (payload_beat),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Mostly no pause, some short ones, a few long ones; now and then a calm stretch.
    function automatic int unsigned draw_pause(inout int calm);
        int unsigned roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 2)
        begin
            calm = $urandom_range(150, 40);
            return 0;
        end
        if (roll < 72)
            return 0;
        if (roll < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 6);
    endfunction

    function automatic void accept_length();
        if (frame_len > cfg_max_len)
            phase = PARSE_DROP;
        else
        begin
            phase = PARSE_MASK;
            pos_count = '0;
        end
    endfunction

    function automatic void predict_unmask(input in_beat_t b, output bit produced,
                                           output out_beat_t r);
        logic [6:0] code;
        logic [1:0] lane;
        produced = 1'b0;
        r = '0;
        if (b.buffer_start)
        begin
            frame_len = '0;
            mask_word = '0;
            pos_count = '0;
            phase = (b.stream_byte == cfg_header) ? PARSE_LEN : PARSE_DROP;
            return;
        end
        lane = pos_count[1:0];
        case (phase)
            PARSE_LEN:
            begin
                code = b.stream_byte[6:0] & LEN_CODE_MASK;
                if (code == LEN_UNSUP)
                    phase = PARSE_DROP;
                else if (code == LEN_EXT16)
                    phase = PARSE_EXT_HI;
                else
                begin
                    frame_len = {9'd0, code};
                    accept_length();
                end
            end
            PARSE_EXT_HI:
            begin
                frame_len = {b.stream_byte, 8'h00};
                phase = PARSE_EXT_LO;
            end
            PARSE_EXT_LO:
            begin
                frame_len = frame_len | {8'h00, b.stream_byte};
                accept_length();
            end
            PARSE_MASK:
            begin
                mask_word[8*lane +: 8] = b.stream_byte;
                pos_count = pos_count + 16'd1;
                if (pos_count >= MASK_BYTES)
                begin
                    pos_count = '0;
                    phase = (frame_len == 16'd0) ? PARSE_IDLE : PARSE_PAYLOAD;
                end
            end
            PARSE_PAYLOAD:
            begin
                r.payload_byte = b.stream_byte ^ mask_word[8*lane +: 8];
                r.payload_position = pos_count;
                r.last_of_payload = ({1'b0, pos_count} + 17'd1) >= {1'b0, frame_len};
                produced = 1'b1;
                pos_count = pos_count + 16'd1;
                if (r.last_of_payload)
                    phase = PARSE_IDLE;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Presents one beat, waits for it to be taken, and records what it should cause.
    task automatic put_byte(input in_beat_t b, input row_kind_e kind, input out_beat_t pinned);
        int unsigned pause;
        bit          produced;
        out_beat_t   r;
        pause = draw_pause(send_calm);
        if (pause != 0)
        begin
            frame_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame_beat <= b;
        @(posedge clk);
        while (frame_stall)
            @(posedge clk);
        if (b.buffer_start || (phase != PARSE_IDLE && phase != PARSE_DROP))
            work_beats++;
        predict_unmask(b, produced, r);
        case (kind)
            ROW_PREDICT:
                if (produced)
                    expected_payload.push_back(r);
            ROW_PINNED:
                expected_payload.push_back(pinned);
            default:
            begin
            end
        endcase
    endtask

    task automatic put_data(input logic [7:0] data, input logic start);
        put_byte('{data, start}, ROW_PREDICT, '0);
    endtask

    task automatic send_junk(input int unsigned count);
        repeat (count) put_data(8'($urandom), 1'b0);
    endtask

    task automatic set_reg(input logic idx, input logic [15:0] value);
        frame_valid <= 1'b0;
        while (expected_payload.size() != 0)
            @(posedge clk);
        // Let any header or mask beat still inside the block settle first.
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_HEADER)
            cfg_header = value[7:0];
        else
            cfg_max_len = value;
    endtask

    // One received buffer: mostly a well-formed frame, sometimes a broken one.
    task automatic send_frame();
        int unsigned roll;
        int unsigned len_total;
        int unsigned n_send;
        roll = $urandom_range(99);
        if (roll < 7)
        begin
            put_data(cfg_header ^ 8'($urandom_range(255, 1)), 1'b1);
            send_junk($urandom_range(6));
            return;
        end
        put_data(cfg_header, 1'b1);
        roll = $urandom_range(99);
        if (roll < 5)
        begin
            put_data({1'($urandom), LEN_UNSUP}, 1'b0);
            send_junk($urandom_range(6));
            return;
        end
        if (roll < 25)
        begin
            len_total = ($urandom_range(99) < 5) ? $urandom_range(65535) : $urandom_range(300);
            put_data({1'($urandom), LEN_EXT16}, 1'b0);
            put_data(8'(len_total >> 8), 1'b0);
            put_data(8'(len_total), 1'b0);
        end
        else
        begin
            len_total = (roll < 32) ? $urandom_range(125, 90) : $urandom_range(20);
            put_data({1'($urandom), 7'(len_total)}, 1'b0);
        end
        if (len_total > cfg_max_len)
        begin
            send_junk($urandom_range(5));
            return;
        end
        n_send = ($urandom_range(99) < 4) ? $urandom_range(MASK_BYTES - 1) : MASK_BYTES;
        send_junk(n_send);
        if (n_send < MASK_BYTES)
            return;
        n_send = len_total;
        if ($urandom_range(99) < 6)
            n_send = $urandom_range(len_total);
        if (n_send > LONGEST_SEND)
            n_send = LONGEST_SEND;
        send_junk(n_send);
        if ($urandom_range(99) < 6)
            send_junk($urandom_range(4, 1));
    endtask

    task automatic run_frames(input int unsigned beat_count);
        int target;
        target = work_beats + beat_count;
        while (work_beats < target)
        begin
            if ($urandom_range(99) < 4)
                send_junk($urandom_range(3, 1));
            send_frame();
        end
    endtask

    // Payload side: check each accepted beat, then choose the stall for the next cycle.
    initial
    begin
        int unsigned pause;
        int          stall_left;
        out_beat_t   want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (payload_valid === 1'b1 && payload_stall === 1'b0)
            begin
                if (expected_payload.size() == 0)
                begin
                    $display("%0t: unexpected payload beat: byte %02h pos %0d last %0b", $time,
                             payload_beat.payload_byte, payload_beat.payload_position,
                             payload_beat.last_of_payload);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_payload.pop_front();
                    if (payload_beat.payload_byte !== want.payload_byte
                        || payload_beat.payload_position !== want.payload_position
                        || payload_beat.last_of_payload !== want.last_of_payload)
                    begin
                        $display("%0t: payload mismatch: expected byte %02h pos %0d last %0b, got byte %02h pos %0d last %0b",
                                 $time, want.payload_byte, want.payload_position,
                                 want.last_of_payload, payload_beat.payload_byte,
                                 payload_beat.payload_position, payload_beat.last_of_payload);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                payload_stall <= 1'b1;
            end
            else
            begin
                pause = draw_pause(recv_calm);
                payload_stall <= (pause != 0);
                if (pause != 0)
                    stall_left = pause - 1;
            end
        end
    end

    initial
    begin
        int drain;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            put_byte(DIRECTED_ROWS[i].beat, DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].pinned);
        run_frames(400);

        // With no payload allowed only zero-length frames get through.
        set_reg(CFG_MAX_LEN, 16'd0);
        set_reg(CFG_HEADER, 16'h0082);
        run_frames(120);

        set_reg(CFG_HEADER, 16'h0000);
        set_reg(CFG_MAX_LEN, 16'hFFFF);
        run_frames(350);

        set_reg(CFG_HEADER, 16'h00FF);
        set_reg(CFG_MAX_LEN, 16'd7);
        run_frames(300);

        set_reg(CFG_HEADER, 16'($urandom_range(255)));
        set_reg(CFG_MAX_LEN, 16'($urandom_range(200, 8)));
        run_frames(300);

        set_reg(CFG_HEADER, {8'h00, HEADER_RESET});
        set_reg(CFG_MAX_LEN, MAX_LEN_RESET);
        run_frames(350);

        frame_valid <= 1'b0;
        drain = 0;
        while (expected_payload.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);
        if (expected_payload.size() != 0)
        begin
            $display("%0t: %0d expected payload beats never arrived", $time,
                     expected_payload.size());
            mismatch_count += expected_payload.size();
        end
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
